>>> hdl/hdrp_pkg.sv
// Shared types and constants for the Ethernet L3/L4 header parser.
package hdrp_pkg;

    // Parse stages of the front end.
    typedef enum logic [3:0] {
        ST_ETH  = 4'd0,
        ST_IP4  = 4'd1,
        ST_IP6  = 4'd2,
        ST_TCP  = 4'd3,
        ST_UDP  = 4'd4,
        ST_ICMP = 4'd5,
        ST_PAY  = 4'd6,
        ST_SKIP = 4'd7
    } stage_t;

    // Record kinds.
    localparam logic [4:0] K_DMAC     = 5'd0;
    localparam logic [4:0] K_SMAC     = 5'd1;
    localparam logic [4:0] K_ETYPE    = 5'd2;
    localparam logic [4:0] K_TOS      = 5'd3;
    localparam logic [4:0] K_TOTLEN   = 5'd4;
    localparam logic [4:0] K_IPID     = 5'd5;
    localparam logic [4:0] K_FRAG     = 5'd6;
    localparam logic [4:0] K_TTL      = 5'd7;
    localparam logic [4:0] K_IP4SRC   = 5'd8;
    localparam logic [4:0] K_IP4DST   = 5'd9;
    localparam logic [4:0] K_IP6PLEN  = 5'd10;
    localparam logic [4:0] K_IP6SRCH  = 5'd11;
    localparam logic [4:0] K_IP6SRCL  = 5'd12;
    localparam logic [4:0] K_IP6DSTH  = 5'd13;
    localparam logic [4:0] K_IP6DSTL  = 5'd14;
    localparam logic [4:0] K_SPORT    = 5'd15;
    localparam logic [4:0] K_DPORT    = 5'd16;
    localparam logic [4:0] K_SEQ      = 5'd17;
    localparam logic [4:0] K_ACK      = 5'd18;
    localparam logic [4:0] K_TFLAGS   = 5'd19;
    localparam logic [4:0] K_WINDOW   = 5'd20;
    localparam logic [4:0] K_UDPLEN   = 5'd21;
    localparam logic [4:0] K_ICMPTYPE = 5'd22;
    localparam logic [4:0] K_ICMPCODE = 5'd23;
    localparam logic [4:0] K_PAYLOAD  = 5'd24;
    localparam logic [4:0] K_END      = 5'd25;

    // Protocol classes.
    localparam logic [2:0] PC_NONE   = 3'd0;
    localparam logic [2:0] PC_TCP    = 3'd1;
    localparam logic [2:0] PC_UDP    = 3'd2;
    localparam logic [2:0] PC_ICMP   = 3'd3;
    localparam logic [2:0] PC_ICMP6  = 3'd4;
    localparam logic [2:0] PC_OTHER  = 3'd5;

    // Frame status codes.
    localparam logic [3:0] S_OK        = 4'd0;
    localparam logic [3:0] S_SHORT_ETH = 4'd1;
    localparam logic [3:0] S_SHORT_IP4 = 4'd2;
    localparam logic [3:0] S_SHORT_IPO = 4'd3;
    localparam logic [3:0] S_SHORT_TCP = 4'd4;
    localparam logic [3:0] S_SHORT_TCO = 4'd5;
    localparam logic [3:0] S_SHORT_UDP = 4'd6;
    localparam logic [3:0] S_SHORT_ICM = 4'd7;
    localparam logic [3:0] S_SHORT_IP6 = 4'd8;
    localparam logic [3:0] S_MALFORMED = 4'd9;

    // Protocol numbers.
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam logic [7:0]  PROTO_ICMP  = 8'd1;
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [7:0]  PROTO_ICMP6 = 8'd58;

    // Depth of the record queue between front and back.
    localparam int QDEPTH = 4;

    // One result record.
    typedef struct packed {
        logic [3:0]  status;
        logic [2:0]  pclass;
        logic [3:0]  vbytes;
        logic [63:0] value;
        logic [4:0]  kind;
        logic        last;
    } rec_t;

    // Records caused by one byte: r0 always, r1 when v1 is set.
    typedef struct packed {
        logic v1;
        rec_t r0;
        rec_t r1;
    } bundle_t;

endpackage

>>> hdl/hdrp_front.sv
// Front end: accepts frame bytes, walks the headers and builds record bundles.
module hdrp_front #(
    parameter int PAYLOAD_BYTES = 16,
    parameter int LENGTH_BITS   = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_valid,
    input  logic [7:0]       data_byte,
    input  logic             end_of_frame,
    output logic             push,
    output hdrp_pkg::bundle_t push_data
);
    import hdrp_pkg::*;

    localparam int TWR = $clog2(PAYLOAD_BYTES + 2);
    localparam int TW  = (TWR < 3) ? 3 : TWR;
    localparam int LB  = LENGTH_BITS;

    logic [LB-1:0] pos_reg, pos_next;
    stage_t        stage_reg, stage_next;
    logic [63:0]   acc_reg, acc_next;
    logic [15:0]   etype_reg, etype_next;
    logic [7:0]    proto_reg, proto_next;
    logic [7:0]    l3end_reg, l3end_next;
    logic [7:0]    l4end_reg, l4end_next;
    logic [TW-1:0] taken_reg, taken_next;
    logic [3:0]    fstat_reg, fstat_next;

    logic [LB-1:0] off;
    logic [LB:0]   p1;
    logic [63:0]   acc_sh;
    logic          hit, fin, emit, flush, v4;
    logic [4:0]    kind;
    rec_t          rec_a, rec_end;
    logic [2:0]    pcls;
    logic [3:0]    st;

    assign acc_sh = {acc_reg[55:0], data_byte};
    assign p1     = {1'b0, pos_reg} + (LB+1)'(1);
    assign v4     = (etype_reg == ETYPE_IPV4);

    // Offset of the current byte within the header being parsed.
    always_comb begin
        unique case (stage_reg)
            ST_ETH:                off = pos_reg;
            ST_IP4, ST_IP6:        off = pos_reg - LB'(14);
            default:               off = pos_reg - LB'(l3end_reg);
        endcase
    end

    // Field decode of the current byte.
    always_comb begin
        hit  = 1'b0;
        fin  = 1'b0;
        kind = K_DMAC;
        unique case (stage_reg)
            ST_ETH: begin
                hit = 1'b1;
                if (off < LB'(6)) begin
                    kind = K_DMAC;  fin = (off == LB'(5));
                end else if (off < LB'(12)) begin
                    kind = K_SMAC;  fin = (off == LB'(11));
                end else begin
                    kind = K_ETYPE; fin = (off == LB'(13));
                end
            end
            ST_IP4: begin
                hit = 1'b1;
                if (off == LB'(1)) begin
                    kind = K_TOS; fin = 1'b1;
                end else if (off == LB'(2) || off == LB'(3)) begin
                    kind = K_TOTLEN; fin = (off == LB'(3));
                end else if (off == LB'(4) || off == LB'(5)) begin
                    kind = K_IPID; fin = (off == LB'(5));
                end else if (off == LB'(6) || off == LB'(7)) begin
                    kind = K_FRAG; fin = (off == LB'(7));
                end else if (off == LB'(8)) begin
                    kind = K_TTL; fin = 1'b1;
                end else if (off >= LB'(12) && off <= LB'(15)) begin
                    kind = K_IP4SRC; fin = (off == LB'(15));
                end else if (off >= LB'(16) && off <= LB'(19)) begin
                    kind = K_IP4DST; fin = (off == LB'(19));
                end else begin
                    hit = 1'b0;
                end
            end
            ST_IP6: begin
                hit = 1'b1;
                if (off == LB'(4) || off == LB'(5)) begin
                    kind = K_IP6PLEN; fin = (off == LB'(5));
                end else if (off == LB'(7)) begin
                    kind = K_TTL; fin = 1'b1;
                end else if (off >= LB'(8) && off <= LB'(15)) begin
                    kind = K_IP6SRCH; fin = (off == LB'(15));
                end else if (off >= LB'(16) && off <= LB'(23)) begin
                    kind = K_IP6SRCL; fin = (off == LB'(23));
                end else if (off >= LB'(24) && off <= LB'(31)) begin
                    kind = K_IP6DSTH; fin = (off == LB'(31));
                end else if (off >= LB'(32) && off <= LB'(39)) begin
                    kind = K_IP6DSTL; fin = (off == LB'(39));
                end else begin
                    hit = 1'b0;
                end
            end
            ST_TCP: begin
                hit = 1'b1;
                if (off == LB'(0) || off == LB'(1)) begin
                    kind = K_SPORT; fin = (off == LB'(1));
                end else if (off == LB'(2) || off == LB'(3)) begin
                    kind = K_DPORT; fin = (off == LB'(3));
                end else if (v4 && off >= LB'(4) && off <= LB'(7)) begin
                    kind = K_SEQ; fin = (off == LB'(7));
                end else if (v4 && off >= LB'(8) && off <= LB'(11)) begin
                    kind = K_ACK; fin = (off == LB'(11));
                end else if (off == LB'(13)) begin
                    kind = K_TFLAGS; fin = 1'b1;
                end else if (v4 && (off == LB'(14) || off == LB'(15))) begin
                    kind = K_WINDOW; fin = (off == LB'(15));
                end else begin
                    hit = 1'b0;
                end
            end
            ST_UDP: begin
                hit = 1'b1;
                if (off == LB'(0) || off == LB'(1)) begin
                    kind = K_SPORT; fin = (off == LB'(1));
                end else if (off == LB'(2) || off == LB'(3)) begin
                    kind = K_DPORT; fin = (off == LB'(3));
                end else if (v4 && (off == LB'(4) || off == LB'(5))) begin
                    kind = K_UDPLEN; fin = (off == LB'(5));
                end else begin
                    hit = 1'b0;
                end
            end
            ST_ICMP: begin
                hit = 1'b1;
                if (off == LB'(0)) begin
                    kind = K_ICMPTYPE; fin = 1'b1;
                end else if (off == LB'(1)) begin
                    kind = K_ICMPCODE; fin = 1'b1;
                end else begin
                    hit = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Per-byte state update, records and stage transitions.
    always_comb begin
        pos_next   = (pos_reg != '1) ? pos_reg + LB'(1) : pos_reg;
        stage_next = stage_reg;
        acc_next   = acc_reg;
        etype_next = etype_reg;
        proto_next = proto_reg;
        l3end_next = l3end_reg;
        l4end_next = l4end_reg;
        taken_next = taken_reg;
        fstat_next = fstat_reg;
        emit       = 1'b0;
        rec_a      = '0;

        // Length fields and protocol capture.
        if (stage_reg == ST_IP4 && pos_reg == LB'(14)) begin
            if (data_byte[3:0] < 4'd5) begin
                fstat_next = S_MALFORMED;
                l3end_next = 8'd34;
            end else begin
                l3end_next = 8'd14 + {2'b00, data_byte[3:0], 2'b00};
            end
        end
        if (stage_reg == ST_IP4 && pos_reg == LB'(23)) proto_next = data_byte;
        if (stage_reg == ST_IP6 && pos_reg == LB'(20)) proto_next = data_byte;
        if (stage_reg == ST_TCP && off == LB'(12)) begin
            if (data_byte[7:4] < 4'd5) fstat_next = S_MALFORMED;
            else l4end_next = l3end_reg + {2'b00, data_byte[7:4], 2'b00};
        end

        // Payload packing.
        if (stage_reg == ST_PAY && 32'(taken_reg) < PAYLOAD_BYTES) begin
            acc_next   = acc_sh;
            taken_next = taken_reg + TW'(1);
            if (taken_next[2:0] == 3'd0) begin
                emit         = 1'b1;
                rec_a.kind   = K_PAYLOAD;
                rec_a.value  = acc_sh;
                rec_a.vbytes = 4'd8;
                acc_next     = '0;
            end
        end

        // Header fields.
        if (stage_reg <= ST_ICMP) begin
            if (!hit) begin
                acc_next = '0;
            end else begin
                acc_next = acc_sh;
                if (fin) begin
                    emit        = 1'b1;
                    rec_a.kind  = kind;
                    rec_a.value = acc_sh;
                    if (kind == K_ETYPE) etype_next = acc_sh[15:0];
                    acc_next = '0;
                end
            end
            if (stage_reg == ST_ETH && pos_reg == LB'(13)) begin
                if (etype_next == ETYPE_IPV4) begin
                    stage_next = ST_IP4;
                end else if (etype_next == ETYPE_IPV6) begin
                    stage_next = ST_IP6;
                    l3end_next = 8'd54;
                end else begin
                    stage_next = ST_SKIP;
                end
            end else if ((stage_reg == ST_IP4 && pos_reg >= LB'(14) &&
                          p1 == (LB+1)'(l3end_next)) ||
                         (stage_reg == ST_IP6 && p1 == (LB+1)'(54))) begin
                // Enter the transport header.
                if (fstat_next == S_MALFORMED) begin
                    stage_next = ST_SKIP;
                end else if (proto_next == PROTO_TCP) begin
                    stage_next = ST_TCP;
                    l4end_next = l3end_next + 8'd20;
                end else if (proto_next == PROTO_UDP) begin
                    stage_next = ST_UDP;
                    l4end_next = l3end_next + 8'd8;
                end else if ((v4 && proto_next == PROTO_ICMP) ||
                             (!v4 && proto_next == PROTO_ICMP6)) begin
                    stage_next = ST_ICMP;
                    l4end_next = l3end_next + 8'd4;
                end else begin
                    stage_next = ST_SKIP;
                end
            end else if (stage_reg >= ST_TCP && p1 == (LB+1)'(l4end_next)) begin
                stage_next = (fstat_next == S_MALFORMED) ? ST_SKIP : ST_PAY;
            end
        end
    end

    // Frame-end class and status, from the state after this byte.
    always_comb begin
        pcls = PC_NONE;
        if (etype_next == ETYPE_IPV4 && pos_next >= LB'(34)) begin
            if (proto_next == PROTO_TCP)       pcls = PC_TCP;
            else if (proto_next == PROTO_UDP)  pcls = PC_UDP;
            else if (proto_next == PROTO_ICMP) pcls = PC_ICMP;
            else                               pcls = PC_OTHER;
        end else if (etype_next == ETYPE_IPV6 && pos_next >= LB'(54)) begin
            if (proto_next == PROTO_TCP)        pcls = PC_TCP;
            else if (proto_next == PROTO_UDP)   pcls = PC_UDP;
            else if (proto_next == PROTO_ICMP6) pcls = PC_ICMP6;
            else                                pcls = PC_OTHER;
        end
        if (fstat_next == S_MALFORMED) begin
            st = S_MALFORMED;
        end else begin
            unique case (stage_next)
                ST_ETH:  st = S_SHORT_ETH;
                ST_IP4:  st = (pos_next < LB'(34)) ? S_SHORT_IP4 : S_SHORT_IPO;
                ST_IP6:  st = S_SHORT_IP6;
                ST_TCP:  st = ((LB+1)'(pos_next) < (LB+1)'(l3end_next) + (LB+1)'(20))
                              ? S_SHORT_TCP : S_SHORT_TCO;
                ST_UDP:  st = S_SHORT_UDP;
                ST_ICMP: st = S_SHORT_ICM;
                default: st = fstat_next;
            endcase
        end
        rec_end        = '0;
        rec_end.kind   = K_END;
        rec_end.value  = 64'(pos_next);
        rec_end.pclass = pcls;
        rec_end.status = st;
        rec_end.last   = 1'b1;
    end

    // Bundle assembly; a partial payload word is flushed before the frame end.
    always_comb begin
        flush     = end_of_frame && stage_next == ST_PAY && taken_next[2:0] != 3'd0;
        push_data = '0;
        if (emit) begin
            push_data.r0 = rec_a;
        end else if (flush) begin
            push_data.r0        = '0;
            push_data.r0.kind   = K_PAYLOAD;
            push_data.r0.value  = acc_next;
            push_data.r0.vbytes = {1'b0, taken_next[2:0]};
        end
        if (emit || flush) begin
            push_data.r1 = rec_end;
            push_data.v1 = end_of_frame;
        end else begin
            push_data.r0 = rec_end;
        end
        push = byte_valid && (emit || flush || end_of_frame);
    end

    // Parser state registers; everything returns to reset at frame end.
    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_valid && end_of_frame)) begin
            pos_reg   <= '0;
            stage_reg <= ST_ETH;
            acc_reg   <= '0;
            etype_reg <= '0;
            proto_reg <= '0;
            l3end_reg <= '0;
            l4end_reg <= '0;
            taken_reg <= '0;
            fstat_reg <= S_OK;
        end else if (byte_valid) begin
            pos_reg   <= pos_next;
            stage_reg <= stage_next;
            acc_reg   <= acc_next;
            etype_reg <= etype_next;
            proto_reg <= proto_next;
            l3end_reg <= l3end_next;
            l4end_reg <= l4end_next;
            taken_reg <= taken_next;
            fstat_reg <= fstat_next;
        end
    end

endmodule

>>> hdl/hdrp_queue.sv
// Short queue of record bundles between the front and back ends.
module hdrp_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  hdrp_pkg::bundle_t push_data,
    output logic              full,
    output logic              q_valid,
    output hdrp_pkg::bundle_t q_data,
    input  logic              pop,
    output logic [$clog2(hdrp_pkg::QDEPTH+1)-1:0] count
);
    import hdrp_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int CW = $clog2(QDEPTH + 1);

    bundle_t         mem [QDEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [CW-1:0]   cnt_reg;

    assign full    = (cnt_reg == CW'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem[rp_reg];
    assign count   = cnt_reg;

    // Storage.
    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= push_data;
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + PW'(1);
            if (pop)  rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + CW'(push) - CW'(pop);
        end
    end

endmodule

>>> hdl/hdrp_back.sv
// Back end: unpacks bundles and presents one record per transfer.
module hdrp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  hdrp_pkg::bundle_t q_data,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output hdrp_pkg::rec_t    out_rec
);
    import hdrp_pkg::*;

    logic hold_reg, nv_reg, adv;
    rec_t cur_reg, nxt_reg;

    assign adv      = !hold_reg || m_tready;
    assign pop      = adv && !(hold_reg && nv_reg) && q_valid;
    assign m_tvalid = hold_reg;
    assign out_rec  = cur_reg;

    // Output register with one pending record behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
            nv_reg   <= 1'b0;
        end else if (adv) begin
            if (hold_reg && nv_reg) begin
                nv_reg <= 1'b0;
            end else begin
                hold_reg <= q_valid;
                nv_reg   <= q_valid && q_data.v1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (hold_reg && nv_reg) begin
                cur_reg <= nxt_reg;
            end else if (q_valid) begin
                cur_reg <= q_data.r0;
                nxt_reg <= q_data.r1;
            end
        end
    end

endmodule

>>> hdl/ethernet_l3_l4_header_parser_core.sv
// Top level of the Ethernet L3/L4 header parser.
// Frame bytes enter one per transfer on the s_ side, tlast on the last byte of
// a frame. Each completed header field (Ethernet, IPv4/IPv6, TCP/UDP/ICMP) gives
// one record on the m_ side, payload goes out in words of up to 8 bytes for the
// first PAYLOAD_BYTES bytes, and every frame closes with a frame-end record
// (tlast high) carrying the length, protocol class and status. The parser takes
// one byte per cycle; the records of a byte (at most two) leave one per output
// transfer, absorbed by a four-entry queue ahead of the output register, so the
// input stalls only when the output side is slower.
module ethernet_l3_l4_header_parser_core #(
    parameter int PAYLOAD_BYTES = 16,
    parameter int LENGTH_BITS   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // end_of_frame
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] record_kind, [68:5] field_value, [72:69] valid_bytes,
    // [75:73] protocol_class, [79:76] status
    output logic [79:0] m_tdata,
    output logic        m_tlast    // last
);
    import hdrp_pkg::*;

    logic    push, full, q_valid, pop;
    bundle_t push_data, q_data;
    rec_t    out_rec;
    logic [$clog2(QDEPTH+1)-1:0] q_count;

    assign s_tready = !full;

    hdrp_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_valid  (s_tvalid && s_tready),
        .data_byte   (s_tdata),
        .end_of_frame(s_tlast),
        .push        (push),
        .push_data   (push_data)
    );

    hdrp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .count    (q_count)
    );

    hdrp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .out_rec (out_rec)
    );

    assign m_tdata = {out_rec.status, out_rec.pclass, out_rec.vbytes,
                      out_rec.value, out_rec.kind};
    assign m_tlast = out_rec.last;

`ifndef SYNTHESIS
    // The queue never takes a bundle while full.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("record queue overflow");

    // Only a frame-end record closes a frame.
    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[4:0] == K_END))
        else $error("tlast on a record that is not a frame end");

    // Valid byte counts appear only on payload words.
    a_vbytes_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[72:69] != 4'd0) |-> (m_tdata[4:0] == K_PAYLOAD))
        else $error("valid_bytes set on a non-payload record");

    // The fill count stays within the queue depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(q_count) <= QDEPTH)
        else $error("record queue count out of range");
`endif

endmodule
